/* rtl/wow_modulated_fractional_delay_macros.svh */
// Assertion macros for the wow fractional delay block.
// Included by the top level; no other dependencies.
`ifndef WOW_MODULATED_FRACTIONAL_DELAY_MACROS_SVH
`define WOW_MODULATED_FRACTIONAL_DELAY_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define WMFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wmfd assertion failed");
// Next-cycle implication.
`define WMFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wmfd assertion failed");
`else
`define WMFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define WMFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/wmfd_pkg.sv */
// Package for the wow fractional delay: word types, sizes, register map,
// quarter-wave sine table. No dependencies.
`timescale 1ns / 1ps

package wmfd_pkg;

  localparam int LINE_DEPTH = 2048;   // power of two
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int PHASE_BITS = 24;

  localparam int SAMPLE_W = 24;
  localparam int DEPTH_W  = 23;
  localparam int STEP_W   = 16;
  localparam int FRAC_W   = 12;

  // clamp for the delay, 12 fraction bits
  localparam logic [39:0] DELAY_LIMIT = 40'((LINE_DEPTH - 2) * 4096);

  // APB register map
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_WOW_DEPTH   = 2'd0;
  localparam logic [1:0] REG_PHASE_STEP  = 2'd1;
  localparam logic [1:0] REG_STEREO_MODE = 2'd2;

  localparam logic [DEPTH_W-1:0] WOW_DEPTH_RST   = '0;
  localparam logic [STEP_W-1:0]  PHASE_STEP_RST  = 16'd245;
  localparam logic               STEREO_MODE_RST = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_word_t;

  // quarter-wave sine, Q1.15, 65 points
  function automatic logic [15:0] quarter_sine(input logic [6:0] idx);
    logic [15:0] v;
    case (idx)
      7'd0:  v = 16'd0;     7'd1:  v = 16'd804;   7'd2:  v = 16'd1608;
      7'd3:  v = 16'd2410;  7'd4:  v = 16'd3212;  7'd5:  v = 16'd4011;
      7'd6:  v = 16'd4808;  7'd7:  v = 16'd5602;  7'd8:  v = 16'd6392;
      7'd9:  v = 16'd7179;  7'd10: v = 16'd7962;  7'd11: v = 16'd8739;
      7'd12: v = 16'd9512;  7'd13: v = 16'd10278; 7'd14: v = 16'd11039;
      7'd15: v = 16'd11793; 7'd16: v = 16'd12539; 7'd17: v = 16'd13279;
      7'd18: v = 16'd14010; 7'd19: v = 16'd14732; 7'd20: v = 16'd15446;
      7'd21: v = 16'd16151; 7'd22: v = 16'd16846; 7'd23: v = 16'd17530;
      7'd24: v = 16'd18204; 7'd25: v = 16'd18868; 7'd26: v = 16'd19519;
      7'd27: v = 16'd20159; 7'd28: v = 16'd20787; 7'd29: v = 16'd21403;
      7'd30: v = 16'd22005; 7'd31: v = 16'd22594; 7'd32: v = 16'd23170;
      7'd33: v = 16'd23731; 7'd34: v = 16'd24279; 7'd35: v = 16'd24811;
      7'd36: v = 16'd25329; 7'd37: v = 16'd25832; 7'd38: v = 16'd26319;
      7'd39: v = 16'd26790; 7'd40: v = 16'd27245; 7'd41: v = 16'd27683;
      7'd42: v = 16'd28105; 7'd43: v = 16'd28510; 7'd44: v = 16'd28898;
      7'd45: v = 16'd29268; 7'd46: v = 16'd29621; 7'd47: v = 16'd29956;
      7'd48: v = 16'd30273; 7'd49: v = 16'd30571; 7'd50: v = 16'd30852;
      7'd51: v = 16'd31113; 7'd52: v = 16'd31356; 7'd53: v = 16'd31580;
      7'd54: v = 16'd31785; 7'd55: v = 16'd31971; 7'd56: v = 16'd32137;
      7'd57: v = 16'd32285; 7'd58: v = 16'd32412; 7'd59: v = 16'd32521;
      7'd60: v = 16'd32609; 7'd61: v = 16'd32678; 7'd62: v = 16'd32728;
      7'd63: v = 16'd32757; 7'd64: v = 16'd32767;
      default: v = 16'd32767;
    endcase
    return v;
  endfunction

endpackage

/* rtl/wow_modulated_fractional_delay.sv */
// Top level of the wow fractional delay: sequencer, LFO, delay lines, APB.
// Depends on wmfd_pkg and wow_modulated_fractional_delay_macros.svh.
`timescale 1ns / 1ps

// Wow (slow pitch drift) for a stereo stream. Each input word is one frame of
// two signed Q1.23 samples; each channel is written into its own 2048-entry
// circular line, and read back at a delay of wow_depth*(0.5+0.5*sin(phase))
// samples, with 12 fraction bits, by linear interpolation between two adjacent
// taps. The shared 24-bit LFO phase advances by phase_step per processed
// frame. The block takes no new frame until the last one is finished: it
// accepts the frame, then does the sine lookup and line write, the depth
// multiply, the two tap reads through the single port of each line memory,
// and the final interpolation sum into the output register. With wow_depth
// at 0 the frame passes through unchanged, skipping those steps, and no state
// moves. With stereo_mode at 0 the right sample passes through and the right
// line is left alone. Entries not yet written since reset read as zero,
// tracked by the write position and a wrap flag per channel, so there is no
// clearing pass after reset. The output register holds a finished word while
// the next frame is accepted; the block only waits in its last cycle when that
// register is still occupied. Registers: wow_depth at 0x0, phase_step at 0x4,
// stereo_mode at 0x8; write them only while the block is idle.

`include "wow_modulated_fractional_delay_macros.svh"

module wow_modulated_fractional_delay (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  wmfd_pkg::in_word_t          in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output wmfd_pkg::out_word_t         out_word_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wmfd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import wmfd_pkg::*;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SIN  = 3'd1;
  localparam logic [2:0] ST_DLY  = 3'd2;
  localparam logic [2:0] ST_RD0  = 3'd3;
  localparam logic [2:0] ST_RD1  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam int PROD_W = SAMPLE_W + FRAC_W + 2;

  // ---------------------------------------------------------------- config
  logic [DEPTH_W-1:0] wow_depth_q;
  logic [STEP_W-1:0]  phase_step_q;
  logic               stereo_mode_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wow_depth_q   <= WOW_DEPTH_RST;
      phase_step_q  <= PHASE_STEP_RST;
      stereo_mode_q <= STEREO_MODE_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_WOW_DEPTH:   wow_depth_q   <= pwdata[DEPTH_W-1:0];
        REG_PHASE_STEP:  phase_step_q  <= pwdata[STEP_W-1:0];
        REG_STEREO_MODE: stereo_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WOW_DEPTH:   prdata = 32'(wow_depth_q);
      REG_PHASE_STEP:  prdata = 32'(phase_step_q);
      REG_STEREO_MODE: prdata = 32'(stereo_mode_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  logic [2:0]            state_q, state_d;
  logic                  bypass_q;
  in_word_t              in_q;
  logic [PHASE_BITS-1:0] lfo_phase_q;
  logic [ADDR_W-1:0]     wp_l_q, wp_r_q;
  logic                  wrap_l_q, wrap_r_q;   // line has been filled once
  logic                  in_acc, out_free, fin_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign fin_load   = (state_q == ST_FIN) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = (wow_depth_q == '0) ? ST_FIN : ST_SIN;
      ST_SIN:  state_d = ST_DLY;
      ST_DLY:  state_d = ST_RD0;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q     <= in_word_i;
      bypass_q <= (wow_depth_q == '0);
    end
  end

  // ------------------------------------------------------------ LFO / sine
  logic [31:0] p_al;
  logic [1:0]  quad;
  logic [22:0] qpos;
  logic [6:0]  s_idx;
  logic [15:0] s_fr, s_lo, s_hi, s_val;
  logic [31:0] s_prod;
  logic [16:0] mod_w;
  logic [15:0] mod_q;

  always_comb begin
    p_al  = 32'(lfo_phase_q) << (32 - PHASE_BITS);
    quad  = p_al[31:30];
    qpos  = quad[0] ? (23'h400000 - {1'b0, p_al[29:8]}) : {1'b0, p_al[29:8]};
    s_idx = qpos[22:16];
    s_fr  = qpos[15:0];
    s_lo  = quarter_sine(s_idx);
    s_hi  = quarter_sine(s_idx + 7'd1);
    s_prod = 32'(s_hi - s_lo) * 32'(s_fr);
    s_val = (s_idx >= 7'd64) ? quarter_sine(7'd64) : (s_lo + s_prod[31:16]);
    mod_w = quad[1] ? (17'd32768 - 17'(s_val)) : (17'd32768 + 17'(s_val));
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SIN) mod_q <= mod_w[15:0];
  end

  // --------------------------------------------------------------- delay
  logic [38:0]       dly_prod;
  logic [39:0]       dly_clamped;
  logic [ADDR_W-1:0] d_q;
  logic [FRAC_W-1:0] f_q;

  always_comb begin
    dly_prod    = 39'(wow_depth_q) * 39'(mod_q);
    dly_clamped = {17'd0, dly_prod[38:16]};
    if (dly_clamped > DELAY_LIMIT) dly_clamped = DELAY_LIMIT;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DLY) begin
      d_q <= ADDR_W'(dly_clamped >> FRAC_W);
      f_q <= dly_clamped[FRAC_W-1:0];
    end
  end

  // ---------------------------------------------------------- delay lines
  logic signed [SAMPLE_W-1:0] left_line_mem  [LINE_DEPTH];
  logic signed [SAMPLE_W-1:0] right_line_mem [LINE_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_l_q, rd_r_q;
  logic                       v_l_q, v_r_q;
  logic [ADDR_W-1:0]          addr_l, addr_r;
  logic                       we_l, we_r, rd_en;

  assign we_l  = (state_q == ST_SIN);
  assign we_r  = (state_q == ST_SIN) && stereo_mode_q;
  assign rd_en = (state_q == ST_RD0) || (state_q == ST_RD1);

  always_comb begin
    if (state_q == ST_SIN) begin
      addr_l = wp_l_q;
      addr_r = wp_r_q;
    end else if (state_q == ST_RD0) begin
      addr_l = wp_l_q - d_q;
      addr_r = wp_r_q - d_q;
    end else begin
      addr_l = wp_l_q - d_q - ADDR_W'(1);
      addr_r = wp_r_q - d_q - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_l) begin
      left_line_mem[addr_l] <= in_q.left_sample;
    end else begin
      rd_l_q <= left_line_mem[addr_l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_r) begin
      right_line_mem[addr_r] <= in_q.right_sample;
    end else begin
      rd_r_q <= right_line_mem[addr_r];
    end
  end

  // entry holds data iff the line wrapped or it lies at or behind the write point
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      v_l_q <= wrap_l_q || (addr_l <= wp_l_q);
      v_r_q <= wrap_r_q || (addr_r <= wp_r_q);
    end
  end

  // ---------------------------------------------------------- interpolate
  logic signed [SAMPLE_W-1:0] tap_l, tap_r;
  logic signed [FRAC_W+1:0]   w0, w1;
  logic signed [PROD_W-1:0]   p0_l_q, p0_r_q, acc_l, acc_r;

  assign tap_l = v_l_q ? rd_l_q : '0;
  assign tap_r = v_r_q ? rd_r_q : '0;
  assign w0    = $signed((FRAC_W+2)'(1 << FRAC_W) - (FRAC_W+2)'(f_q));
  assign w1    = $signed((FRAC_W+2)'(f_q));

  // first tap lands in RD1, second in FIN
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD1) begin
      p0_l_q <= PROD_W'(tap_l) * PROD_W'(w0);
      p0_r_q <= PROD_W'(tap_r) * PROD_W'(w0);
    end
  end

  assign acc_l = p0_l_q + PROD_W'(tap_l) * PROD_W'(w1) + PROD_W'(1 << (FRAC_W - 1));
  assign acc_r = p0_r_q + PROD_W'(tap_r) * PROD_W'(w1) + PROD_W'(1 << (FRAC_W - 1));

  // ---------------------------------------------------------- output/state
  out_word_t out_word_q;
  logic      out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      if (bypass_q) begin
        out_word_q.left_out  <= in_q.left_sample;
        out_word_q.right_out <= in_q.right_sample;
      end else begin
        out_word_q.left_out  <= acc_l[FRAC_W +: SAMPLE_W];
        out_word_q.right_out <= stereo_mode_q ? acc_r[FRAC_W +: SAMPLE_W]
                                              : in_q.right_sample;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfo_phase_q <= '0;
      wp_l_q      <= '0;
      wp_r_q      <= '0;
      wrap_l_q    <= 1'b0;
      wrap_r_q    <= 1'b0;
    end else if (fin_load && !bypass_q) begin
      lfo_phase_q <= lfo_phase_q + PHASE_BITS'(phase_step_q);
      wp_l_q      <= wp_l_q + ADDR_W'(1);
      if (wp_l_q == '1) wrap_l_q <= 1'b1;
      if (stereo_mode_q) begin
        wp_r_q <= wp_r_q + ADDR_W'(1);
        if (wp_r_q == '1) wrap_r_q <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------- assertions
  `WMFD_ASSERT_NEXT(a_active_starts, clk_i, rst_ni, in_acc && (wow_depth_q != '0), state_q == ST_SIN)
  `WMFD_ASSERT_NEXT(a_bypass_frozen, clk_i, rst_ni, fin_load && bypass_q, $stable(lfo_phase_q) && $stable(wp_l_q) && $stable(wp_r_q))
  `WMFD_ASSERT_NEXT(a_fin_delivers, clk_i, rst_ni, fin_load, (state_q == ST_IDLE) && out_valid_q)
  `WMFD_ASSERT_NOW(a_write_only_busy, clk_i, rst_ni, we_l || rd_en, !bypass_q)

endmodule

/* sim/wow_modulated_fractional_delay_tb.sv */
// Self-checking testbench for the wow fractional delay: APB register setup,
// directed and random stereo frames, scoreboard against an in-bench predictor.
// Depends on wmfd_pkg and the wow_modulated_fractional_delay RTL.
`timescale 1ns / 1ps

module wow_modulated_fractional_delay_tb;
  import wmfd_pkg::*;

  // register byte addresses (index * 4) plus one hole past the map
  localparam logic [CFG_AW-1:0] ADDR_DEPTH  = {REG_WOW_DEPTH, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_STEP   = {REG_PHASE_STEP, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_STEREO = {REG_STEREO_MODE, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_SPARE  = 4'hC;

  localparam int STALL_LIMIT = 2000;  // cycles without any word moving

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_word_t            in_word_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_word_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  wow_modulated_fractional_delay DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of both delay lines, write pointers, LFO phase
  // and the three registers.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] left_hist  [LINE_DEPTH];
  logic signed [SAMPLE_W-1:0] right_hist [LINE_DEPTH];
  logic [ADDR_W-1:0]          write_ptr  [2];
  logic [PHASE_BITS-1:0]      lfo_acc;
  logic [DEPTH_W-1:0]         depth_cfg;
  logic [STEP_W-1:0]          step_cfg;
  logic                       stereo_cfg;

  out_word_t expected_frames [$];
  int        errors = 0;
  bit        no_idle = 1'b0;   // set for stretches with no gaps and no stalls

  // quarter-wave sine, Q1.15, 65 points (0 .. pi/2)
  int sine_pts [65] = '{
        0,   804,  1608,  2410,  3212,  4011,  4808,  5602,
     6392,  7179,  7962,  8739,  9512, 10278, 11039, 11793,
    12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
    18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
    23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
    27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
    30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
    32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
    32767
  };

  // LFO sine: top two phase bits pick the quadrant, the rest is a 6.16
  // quarter-wave position, mirrored in odd quadrants, negated in the back half.
  function automatic int lfo_sine(input logic [PHASE_BITS-1:0] ph);
    logic [1:0]  quad;
    logic [22:0] q;
    int          idx;
    int          fr;
    int          s;
    quad = ph[23:22];
    q    = {1'b0, ph[21:0]};
    if (quad[0]) q = 23'h400000 - q;
    idx = int'(q[22:16]);
    fr  = int'(q[15:0]);
    if (idx >= 64) s = sine_pts[64];
    else s = sine_pts[idx] + (((sine_pts[idx+1] - sine_pts[idx]) * fr) >> 16);
    return quad[1] ? -s : s;
  endfunction

  // Write one channel's sample, read the two taps behind it and blend them.
  function automatic logic [SAMPLE_W-1:0] tap_blend(input bit ch,
                                                    input logic signed [SAMPLE_W-1:0] s,
                                                    input logic [ADDR_W-1:0] d,
                                                    input int fr);
    logic [ADDR_W-1:0] pos;
    logic [ADDR_W-1:0] r0;
    logic [ADDR_W-1:0] r1;
    int                t0;
    int                t1;
    longint            acc;
    pos = write_ptr[ch];
    if (ch) right_hist[pos] = s;
    else left_hist[pos] = s;
    r0 = pos - d;
    r1 = pos - d - ADDR_W'(1);
    t0 = ch ? int'(right_hist[r0]) : int'(left_hist[r0]);
    t1 = ch ? int'(right_hist[r1]) : int'(left_hist[r1]);
    acc = longint'(t0) * (4096 - fr) + longint'(t1) * fr + 2048;
    write_ptr[ch] = pos + ADDR_W'(1);
    return acc[35:12];   // floor(acc / 4096), low 24 bits
  endfunction

  function automatic void wow_predict(input in_word_t w);
    out_word_t   r;
    int          md;
    logic [39:0] dly;
    r.left_out  = w.left_sample;
    r.right_out = w.right_sample;
    // zero depth: straight through, nothing moves
    if (depth_cfg != '0) begin
      md  = 32768 + lfo_sine(lfo_acc);
      dly = (40'(depth_cfg) * 40'(md)) >> 16;
      if (dly > DELAY_LIMIT) dly = DELAY_LIMIT;
      r.left_out = tap_blend(1'b0, w.left_sample, dly[22:12], int'(dly[11:0]));
      if (stereo_cfg)
        r.right_out = tap_blend(1'b1, w.right_sample, dly[22:12], int'(dly[11:0]));
      lfo_acc = lfo_acc + PHASE_BITS'(step_cfg);
    end
    expected_frames = {expected_frames, r};
  endfunction

  // every accepted input word feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) wow_predict(in_word_i);
  end

  // scoreboard: each output word against the oldest expectation
  always @(posedge clk_i) begin : check_output
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_frames.size() == 0) begin
        errors++;
        $error("output word with nothing expected: left %0d right %0d",
               out_word_o.left_out, out_word_o.right_out);
      end else begin
        want = expected_frames.pop_front();
        if (out_word_o.left_out !== want.left_out) begin
          errors++;
          $error("left_out: expected %0d, got %0d", want.left_out, out_word_o.left_out);
        end
        if (out_word_o.right_out !== want.right_out) begin
          errors++;
          $error("right_out: expected %0d, got %0d", want.right_out, out_word_o.right_out);
        end
      end
    end
  end

  // receiver backpressure, ~12% of cycles unless in a quiet stretch
  always @(posedge clk_i) begin
    out_stall_i <= no_idle ? 1'b0 : ($urandom_range(99) < 12);
  end

  // watchdog: ends the run if no word moves on either channel for too long
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // APB and stream helpers. All are entered at a rising edge.
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [CFG_AW-1:0] a, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (a)
      ADDR_DEPTH:  depth_cfg  = d[DEPTH_W-1:0];
      ADDR_STEP:   step_cfg   = d[STEP_W-1:0];
      ADDR_STEREO: stereo_cfg = d[0];
      default: ;   // hole in the map, ignored
    endcase
    @(posedge clk_i);  // bus returns to idle between transfers
  endtask

  task automatic apb_read(input logic [CFG_AW-1:0] a, output logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_regs();
    logic [31:0] v;
    apb_read(ADDR_DEPTH, v);
    if (v !== 32'(depth_cfg)) begin
      errors++;
      $error("wow_depth: expected %0d, got %0d", depth_cfg, v);
    end
    apb_read(ADDR_STEP, v);
    if (v !== 32'(step_cfg)) begin
      errors++;
      $error("phase_step: expected %0d, got %0d", step_cfg, v);
    end
    apb_read(ADDR_STEREO, v);
    if (v !== 32'(stereo_cfg)) begin
      errors++;
      $error("stereo_mode: expected %0d, got %0d", stereo_cfg, v);
    end
  endtask

  // Drop valid and wait until every expected word is out. The extra edge
  // lets the input monitor log the word accepted in this step.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_frames.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [DEPTH_W-1:0] depth,
                            input logic [STEP_W-1:0] step,
                            input logic stereo);
    settle();
    apb_write(ADDR_DEPTH, 32'(depth));
    apb_write(ADDR_STEP, 32'(step));
    apb_write(ADDR_STEREO, 32'(stereo));
    check_regs();
  endtask

  // Send one frame; valid stays up after acceptance unless a gap is drawn.
  task automatic send_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
    in_valid_i             <= 1'b1;
    in_word_i.left_sample  <= l;
    in_word_i.right_sample <= r;
    do @(posedge clk_i); while (in_stall_o);
    if (!no_idle && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_frame(rand_sample(), rand_sample());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset values read back; a write past the map changes nothing
  task automatic test_reset_registers();
    check_regs();
    apb_write(ADDR_SPARE, $urandom);
    check_regs();
  endtask

  // depth 0 after reset: words pass untouched, no state moves
  task automatic test_bypass();
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h000000, 24'hFFFFFF);
    send_frame(24'hFFFFFF, 24'h000001);
  endtask

  // delays in stereo: short fixed ones with the phase frozen at step 0, then a moving LFO
  task automatic test_short_delay_stereo();
    // smallest nonzero depth: zero delay, output is the word just written
    set_config(23'd1, 16'd0, 1'b1);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h123456, 24'hEDCBA9);
    // mod = 1/2 at phase 0: delay 1 + 1024/4096 samples
    set_config(23'h2801, 16'd0, 1'b1);
    send_frame(24'h7FFFFF, 24'h7FFFFF);
    send_frame(24'h800000, 24'h800000);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    // largest step: the LFO now moves every frame
    set_config(23'h5A5A5, 16'hFFFF, 1'b1);
    send_frame(24'h000000, 24'hFFFFFF);
    send_frame(24'hFFFFFF, 24'h000000);
  endtask

  // mono: right passes through, right line and pointer untouched
  task automatic test_mono();
    set_config(23'h03_3333, 16'd1234, 1'b0);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h55AA55, 24'hAA55AA);
    send_frame(24'hAA55AA, 24'h55AA55);
    send_frame(24'h000001, 24'hFFFFFE);
  endtask

  // Full-scale depth with the largest step: one LFO turn is 256 frames, so
  // the sweep passes the sine peak where the delay has to be clamped.
  // Run as one long stretch without gaps or stalls.
  task automatic test_clamp_sweep();
    set_config(23'h7FFFFF, 16'hFFFF, 1'b1);
    no_idle = 1'b1;
    send_random(260);
    no_idle = 1'b0;
  endtask

  // random settings, mostly mid-range, with the extremes mixed in
  task automatic test_random_configs();
    logic [DEPTH_W-1:0] depth;
    logic [STEP_W-1:0]  step;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(5))
        0: depth = '0;
        1: depth = DEPTH_W'($urandom_range(4095, 1));
        2: depth = DEPTH_W'($urandom_range(65535, 4096));
        3: depth = 23'h7FFFFF;
        default: depth = DEPTH_W'($urandom);
      endcase
      if (ph == 1) depth = 23'h1F_0000;  // sure to move state in the pause phase
      case ($urandom_range(3))
        0: step = '0;
        1: step = 16'hFFFF;
        2: step = STEP_W'($urandom_range(2047));
        default: step = STEP_W'($urandom);
      endcase
      set_config(depth, step, 1'($urandom_range(1)));
      send_random(45);
      // sender holds off until the pipeline has fully drained
      if (ph == 1) settle();
      send_random(45);
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    foreach (left_hist[i]) begin
      left_hist[i]  = '0;
      right_hist[i] = '0;
    end
    write_ptr[0] = '0;
    write_ptr[1] = '0;
    lfo_acc      = '0;
    depth_cfg    = WOW_DEPTH_RST;
    step_cfg     = PHASE_STEP_RST;
    stereo_cfg   = STEREO_MODE_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_registers();
    test_bypass();
    test_short_delay_stereo();
    test_mono();
    test_clamp_sweep();
    test_random_configs();

    settle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/wmfd_pkg.sv
rtl/wow_modulated_fractional_delay.sv
sim/wow_modulated_fractional_delay_tb.sv
